>>> hw/rtl/horner_polynomial_evaluator_macros.svh
// assertion macros used by the checker file
`ifndef HORNER_POLYNOMIAL_EVALUATOR_MACROS_SVH
`define HORNER_POLYNOMIAL_EVALUATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define HPE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define HPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/hpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hpe_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int ORDER_W   = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // register indexes
    localparam cfg_idx_t CFG_ORDER     = 3'd0;
    localparam cfg_idx_t CFG_COEF_BASE = 3'd1;

    // control that travels along the cell chain with each item
    typedef struct packed {
        logic valid;
        logic last;
        logic sat;
    } hpe_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/hpe_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module hpe_regs
    import hpe_pkg::*;
#(
    parameter int MAX_ORDER  = 6,
    parameter int DATA_WIDTH = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  cfg_idx_t                             cfg_index,
    input  logic [DATA_WIDTH-1:0]                cfg_data,
    output logic [ORDER_W-1:0]                   order_eff,
    output logic [MAX_ORDER:0][DATA_WIDTH-1:0]   coef
);

    logic [ORDER_W-1:0]                 order_reg;
    logic [ORDER_W-1:0]                 order_next;
    logic [MAX_ORDER:0][DATA_WIDTH-1:0] coef_reg;
    logic [MAX_ORDER:0][DATA_WIDTH-1:0] coef_next;

    always_comb
    begin
        order_next = order_reg;
        coef_next  = coef_reg;
        if (cfg_valid)
        begin
            if (cfg_index == CFG_ORDER)
            begin
                order_next = cfg_data[ORDER_W-1:0];
            end
            for (int k = 0; k <= MAX_ORDER; k++)
            begin
                if (cfg_index == CFG_COEF_BASE + CFG_IDX_W'(k))
                begin
                    coef_next[k] = cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= '0;
            coef_reg  <= '0;
        end
        else
        begin
            order_reg <= order_next;
            coef_reg  <= coef_next;
        end
    end

    // orders above the chain length run the full chain
    assign order_eff = (order_reg > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_reg;
    assign coef      = coef_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hpe_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module hpe_cell
    import hpe_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         active,
    input  logic signed [DATA_WIDTH-1:0] coef,
    input  hpe_ctrl_t                    in_ctrl,
    input  logic signed [DATA_WIDTH-1:0] in_x,
    input  logic signed [DATA_WIDTH-1:0] in_acc,
    output hpe_ctrl_t                    out_ctrl,
    output logic signed [DATA_WIDTH-1:0] out_x,
    output logic signed [DATA_WIDTH-1:0] out_acc
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int SW = 2 * DATA_WIDTH + FRAC_BITS + 2;

    localparam logic signed [SW-1:0] HI =
        {{(SW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [SW-1:0] LO =
        {{(SW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    // multiply stage
    hpe_ctrl_t                    ctrl_a_reg;
    hpe_ctrl_t                    ctrl_a_next;
    logic signed [DATA_WIDTH-1:0] x_a_reg;
    logic signed [DATA_WIDTH-1:0] acc_a_reg;
    logic signed [PW-1:0]         prod_a_reg;
    logic signed [PW-1:0]         prod_a_next;
    logic                         act_a_reg;

    // round, add and saturate stage
    hpe_ctrl_t                    ctrl_b_reg;
    hpe_ctrl_t                    ctrl_b_next;
    logic signed [DATA_WIDTH-1:0] x_b_reg;
    logic signed [DATA_WIDTH-1:0] acc_b_reg;
    logic signed [DATA_WIDTH-1:0] acc_b_next;
    logic                         sat_b_next;
    logic signed [SW-1:0]         sum_b;
    logic signed [SW-1:0]         quot_b;
    logic signed [SW-1:0]         s_b;

    assign ctrl_a_next = in_ctrl;
    assign prod_a_next = in_acc * in_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
        end
        else
        begin
            ctrl_a_reg <= ctrl_a_next;
            ctrl_b_reg <= ctrl_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_a_reg    <= in_x;
        acc_a_reg  <= in_acc;
        prod_a_reg <= prod_a_next;
        act_a_reg  <= active;
        x_b_reg    <= x_a_reg;
        acc_b_reg  <= acc_b_next;
    end

    // round half up: floor((p + half) / 2^frac)
    assign sum_b  = SW'(prod_a_reg) + HALF;
    assign quot_b = sum_b >>> FRAC_BITS;
    assign s_b    = quot_b + SW'(coef);

    always_comb
    begin
        acc_b_next = acc_a_reg;
        sat_b_next = ctrl_a_reg.sat;
        if (act_a_reg)
        begin
            if (s_b > HI)
            begin
                acc_b_next = HI[DATA_WIDTH-1:0];
                sat_b_next = 1'b1;
            end
            else if (s_b < LO)
            begin
                acc_b_next = LO[DATA_WIDTH-1:0];
                sat_b_next = 1'b1;
            end
            else
            begin
                acc_b_next = s_b[DATA_WIDTH-1:0];
            end
        end
    end

    always_comb
    begin
        ctrl_b_next       = ctrl_a_reg;
        ctrl_b_next.sat   = sat_b_next;
    end

    assign out_ctrl = ctrl_b_reg;
    assign out_x    = x_b_reg;
    assign out_acc  = acc_b_reg;

endmodule

`default_nettype wire

>>> hw/rtl/horner_polynomial_evaluator.sv
`timescale 1ns / 1ps
`default_nettype none

// Horner polynomial evaluator. One item (arg_value, arg_last) is taken on every clock edge
// with start high and busy low, so a new sample can enter each cycle. The result appears
// at the end of the cell chain with done high for one cycle; the receiver cannot hold it
// off and must take it then. The chain has MAX_ORDER Horner cells, each with a registered
// multiply stage and a registered round/add/saturate stage; lower orders pass through the
// idle cells unchanged, so the latency does not depend on the programmed order. busy is
// high only in reset and the first cycle after it. Registers are written through
// cfg_valid/cfg_index/cfg_data (cfg_ready is always high) and must only change while no
// item is in flight.
module horner_polynomial_evaluator
    import hpe_pkg::*;
#(
    parameter int MAX_ORDER  = 6,
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] arg_value,
    input  logic                         arg_last,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] poly_value,
    output logic                         saturated,
    output logic                         value_last,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  cfg_idx_t                     cfg_index,
    input  logic [DATA_WIDTH-1:0]        cfg_data
);

    localparam int OSEL_W = $clog2(MAX_ORDER + 1);

    logic                               busy_reg;
    logic                               busy_next;
    logic [ORDER_W-1:0]                 order_eff;
    logic [MAX_ORDER:0][DATA_WIDTH-1:0] coef;
    logic [MAX_ORDER-1:0]               cell_active;

    hpe_ctrl_t                    ctrl_chain [MAX_ORDER+1];
    logic signed [DATA_WIDTH-1:0] x_chain    [MAX_ORDER+1];
    logic signed [DATA_WIDTH-1:0] acc_chain  [MAX_ORDER+1];

    assign busy_next = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    assign busy      = busy_reg;
    assign cfg_ready = 1'b1;

    hpe_regs #(
        .MAX_ORDER  (MAX_ORDER),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .order_eff (order_eff),
        .coef      (coef)
    );

    // the accumulator enters holding the top coefficient
    always_comb
    begin
        ctrl_chain[0].valid = start & ~busy_reg;
        ctrl_chain[0].last  = arg_last;
        ctrl_chain[0].sat   = 1'b0;
    end

    assign x_chain[0]   = arg_value;
    assign acc_chain[0] = $signed(coef[order_eff[OSEL_W-1:0]]);

    // cell j applies coefficient MAX_ORDER-1-j, so the last step always lands in the last cell
    for (genvar j = 0; j < MAX_ORDER; j++)
    begin : g_cell
        localparam int M = MAX_ORDER - 1 - j;

        assign cell_active[j] = (order_eff > ORDER_W'(M));

        hpe_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .active   (cell_active[j]),
            .coef     ($signed(coef[M])),
            .in_ctrl  (ctrl_chain[j]),
            .in_x     (x_chain[j]),
            .in_acc   (acc_chain[j]),
            .out_ctrl (ctrl_chain[j+1]),
            .out_x    (x_chain[j+1]),
            .out_acc  (acc_chain[j+1])
        );
    end

    assign done       = ctrl_chain[MAX_ORDER].valid;
    assign saturated  = ctrl_chain[MAX_ORDER].sat;
    assign value_last = ctrl_chain[MAX_ORDER].last;
    assign poly_value = acc_chain[MAX_ORDER];

endmodule

`default_nettype wire

>>> hw/rtl/hpe_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "horner_polynomial_evaluator_macros.svh"

module hpe_checker #(
    parameter int LATENCY = 12
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  logic arg_last,
    input  logic done,
    input  logic value_last
);

    // every result comes from an item that the block took at its input
    `HPE_ASSERT_IMPL(a_done_latency, done, $past(start && !busy, LATENCY), "result without item")

    // the last marker travels with its item
    `HPE_ASSERT_IMPL(a_last_kept, done, value_last == $past(arg_last, LATENCY), "last marker lost")

    // no item is taken on the first edge out of reset
    `HPE_ASSERT_IMPL(a_busy_reset, $rose(rst_n), busy, "busy low at reset release")

    // after that the block is open for items
    `HPE_ASSERT_NEXT(a_busy_clear, $rose(rst_n), !busy, "busy stuck after reset")

endmodule

bind horner_polynomial_evaluator hpe_checker #(
    .LATENCY (2 * MAX_ORDER)
) u_hpe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .arg_last   (arg_last),
    .done       (done),
    .value_last (value_last)
);

`default_nettype wire
